>>> design/mme_pkg.sv
`timescale 1ns / 1ps
package mme_pkg;

  localparam int DIM    = 16;
  localparam int DEPTH  = DIM * DIM;
  localparam int IDX_W  = $clog2(DIM);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = 5;
  localparam int ROW_W  = 4;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int CMP_W  = (SIZE_W > IDX_W + 1) ? SIZE_W : IDX_W + 1;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_READ_C  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_c;
    logic             start;
    logic             push_done;
    logic             mac_v;
    logic             mac_first;
    logic             mac_last;
    logic [IDX_W-1:0] mac_i;
    logic [IDX_W-1:0] mac_j;
    logic [IDX_W-1:0] mac_k;
    logic [IDX_W-1:0] nm1;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
    logic pipe_busy;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(32'(r) * 32'(DIM) + 32'(c));
  endfunction

  function automatic logic in_range(input logic [ROW_W-1:0] v);
    return CMP_W'(v) < CMP_W'(DIM);
  endfunction

endpackage

>>> design/mme_ctrl.sv
`timescale 1ns / 1ps
module mme_ctrl import mme_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_stall,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  input  dp_stat_t          stat,
  output ctl_cmd_t          cmd
);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] active_size_r;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, nm1_r, nm1_nxt;
  logic [CMP_W-1:0]  eff;
  logic [IDX_W-1:0]  eff_nm1;

  assign cfg_ready = 1'b1;

  always_comb begin
    eff = CMP_W'(active_size_r);
    if (eff == '0) eff = CMP_W'(1);
    if (eff > CMP_W'(DIM)) eff = CMP_W'(DIM);
    eff_nm1 = IDX_W'(eff - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      active_size_r <= SIZE_W'(16);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) active_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    nm1_r <= nm1_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    nm1_nxt   = nm1_r;
    cmd       = '0;
    cmd.nm1   = eff_nm1;
    cmd.mac_i = i_r;
    cmd.mac_j = j_r;
    cmd.mac_k = k_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = (cmd_t'(in_command) == CMD_READ_C) && stat.out_full && out_stall;
        if (in_valid && !in_stall) begin
          unique case (cmd_t'(in_command))
            CMD_LOAD_A: cmd.wr_a = 1'b1;
            CMD_LOAD_B: cmd.wr_b = 1'b1;
            CMD_COMPUTE: begin
              cmd.start = 1'b1;
              nm1_nxt   = eff_nm1;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_MAC;
            end
            CMD_READ_C: cmd.rd_c = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac_v     = 1'b1;
        cmd.mac_first = (k_r == '0);
        cmd.mac_last  = (k_r == nm1_r);
        if (k_r == nm1_r) begin
          k_nxt = '0;
          if (j_r == nm1_r) begin
            j_nxt = '0;
            if (i_r == nm1_r) state_nxt = ST_DRAIN;
            else i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && (!stat.out_full || !out_stall)) begin
          cmd.push_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> design/mme_datapath.sv
`timescale 1ns / 1ps
module mme_datapath import mme_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  ctl_cmd_t                cmd,
  output dp_stat_t                stat,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic [ROW_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] out_result
);

  logic signed [VAL_W-1:0]  mem_a [DEPTH];
  logic signed [VAL_W-1:0]  mem_b [DEPTH];
  logic signed [ACC_W-1:0]  mem_c [DEPTH];

  logic signed [VAL_W-1:0]  a_rd_r, b_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, c_rd_r;
  logic                     v1_r, v2_r, first1_r, first2_r, last1_r, last2_r;
  logic [ADDR_W-1:0]        caddr1_r, caddr2_r;
  logic                     computed_r, out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         last_nm1_r;
  logic                     kind_r, zero_r;
  logic [ROW_W-1:0]         row_r, col_r;

  logic                     in_bounds, rd_zero;
  logic [ADDR_W-1:0]        io_addr, addr_a, addr_b;

  assign in_bounds = in_range(in_row) && in_range(in_col);
  assign io_addr   = in_bounds ? addr_of(IDX_W'(in_row), IDX_W'(in_col)) : '0;
  assign addr_a    = addr_of(cmd.mac_i, cmd.mac_k);
  assign addr_b    = addr_of(cmd.mac_k, cmd.mac_j);
  assign rd_zero   = !in_bounds || !computed_r ||
                     (CMP_W'(in_row) > CMP_W'(last_nm1_r)) ||
                     (CMP_W'(in_col) > CMP_W'(last_nm1_r));
  assign acc_nxt = first2_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  assign out_valid_nxt = cmd.rd_c || cmd.push_done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      computed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.mac_v;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
      if (cmd.start) computed_r <= 1'b1;
    end
  end

  // multiply-accumulate pipeline: read, product, accumulate
  always_ff @(posedge clk) begin
    if (cmd.wr_a && in_bounds) mem_a[io_addr] <= in_value;
    if (cmd.wr_b && in_bounds) mem_b[io_addr] <= in_value;
    if (cmd.mac_v) begin
      a_rd_r <= mem_a[addr_a];
      b_rd_r <= mem_b[addr_b];
    end
    first1_r <= cmd.mac_first;
    last1_r  <= cmd.mac_last;
    caddr1_r <= addr_of(cmd.mac_i, cmd.mac_j);
    first2_r <= first1_r;
    last2_r  <= last1_r;
    caddr2_r <= caddr1_r;
    prod_r   <= a_rd_r * b_rd_r;
    if (v2_r) acc_r <= acc_nxt;
    if (v2_r && last2_r) mem_c[caddr2_r] <= acc_nxt;
    if (cmd.start) last_nm1_r <= cmd.nm1;
    if (cmd.rd_c) begin
      c_rd_r <= mem_c[io_addr];
      kind_r <= KIND_READ;
      row_r  <= in_row;
      col_r  <= in_col;
      zero_r <= rd_zero;
    end else if (cmd.push_done) begin
      kind_r <= KIND_DONE;
      row_r  <= '0;
      col_r  <= '0;
      zero_r <= 1'b1;
    end
  end

  assign stat.out_full  = out_valid_r;
  assign stat.pipe_busy = v1_r || v2_r;

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_row    = row_r;
  assign out_col    = col_r;
  assign out_result = zero_r ? '0 : c_rd_r;

endmodule

>>> design/matrix_multiply_engine_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall   in_command, in_row, in_col, in_value
// out_      output     out_valid/out_stall out_kind, out_row, out_col, out_result
// cfg_      input      cfg_valid/cfg_ready cfg_data (active_size)
//
// loads write the memory as they are accepted; a read lands in the output register in the cycle after its transfer
// compute, n the clamped size, runs over the n-by-n corner: one multiply-accumulate per cycle
// through a single multiplier fed by one read port on each of the a and b memories
// reset: synchronous on rst_n; clears control state, c reads as zero until the first compute
// every item is held off while a compute runs; otherwise only a read is held off,
// while the output register is full and stalled
module matrix_multiply_engine_unit import mme_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [ROW_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] out_result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mme_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .cmd        (cmd)
  );

  mme_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_result (out_result)
  );

endmodule

>>> design/mme_checker.sv
`timescale 1ns / 1ps
module mme_checker import mme_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_command,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_kind,
  input logic [ROW_W-1:0]        out_row,
  input logic [ROW_W-1:0]        out_col,
  input logic signed [ACC_W-1:0] out_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (cmd_t'(in_command) == CMD_COMPUTE) |=> in_stall)
    else $error("input taken during compute");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE) |->
      (out_row == '0) && (out_col == '0) && (out_result == '0))
    else $error("done result carries data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply_engine_unit mme_checker u_chk (.*);

>>> sim/matrix_multiply_engine_unit_checker.sv
`timescale 1ns / 1ps
module matrix_multiply_engine_unit_checker import mme_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_kind,
  input  logic [ROW_W-1:0]        out_row,
  input  logic [ROW_W-1:0]        out_col,
  input  logic signed [ACC_W-1:0] out_result,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic                    kind;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
  } c_word_t;

  logic signed [VAL_W-1:0] mat_a [DEPTH];
  logic signed [VAL_W-1:0] mat_b [DEPTH];
  logic signed [ACC_W-1:0] mat_c [DEPTH];
  logic [SIZE_W-1:0]       size_reg = SIZE_W'(DIM);
  c_word_t                 awaited_words [$];
  int                      mismatches = 0;

  // exact product of the active corner, everything else cleared
  task automatic multiply_corner();
    int n;
    int i;
    int j;
    int k;
    logic signed [ACC_W-1:0] acc;
    n = int'(size_reg);
    if (n < 1) n = 1;
    if (n > DIM) n = DIM;
    foreach (mat_c[x]) mat_c[x] = '0;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        acc = '0;
        for (k = 0; k < n; k++) begin
          acc = acc + mat_a[i * DIM + k] * mat_b[k * DIM + j];
        end
        mat_c[i * DIM + j] = acc;
      end
    end
  endtask

  always @(posedge clk) begin
    c_word_t got;
    c_word_t want;
    int idx;
    if (!rst_n) begin
      foreach (mat_c[x]) mat_c[x] = '0;
      size_reg = SIZE_W'(DIM);
      awaited_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      // result side first: nothing accepted at this edge can already be out
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_row, out_col, out_result};
        if (awaited_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind %0d row %0d col %0d value %0d",
                     $realtime, got.kind, got.row, got.col, got.value);
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind || got.row !== want.row ||
              got.col !== want.col || got.value !== want.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected kind %0d row %0d col %0d value %0d, %s %0d %0d %0d %0d",
                       $realtime, want.kind, want.row, want.col, want.value,
                       "got", got.kind, got.row, got.col, got.value);
          end
        end
      end
      if (in_valid && !in_stall) begin
        idx = int'(in_row) * DIM + int'(in_col);
        case (cmd_t'(in_command))
          CMD_LOAD_A: mat_a[idx] = in_value;
          CMD_LOAD_B: mat_b[idx] = in_value;
          CMD_COMPUTE: begin
            multiply_corner();
            awaited_words.push_back('{KIND_DONE, '0, '0, '0});
          end
          default: awaited_words.push_back('{KIND_READ, in_row, in_col, mat_c[idx]});
        endcase
      end
    end
    fail_count <= mismatches;
    pending <= awaited_words.size();
  end

endmodule

>>> sim/matrix_multiply_engine_unit_tb.sv
`timescale 1ns / 1ps
module matrix_multiply_engine_unit_tb import mme_pkg::*;;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_command = CMD_LOAD_A;
  logic [ROW_W-1:0]        in_row = '0;
  logic [ROW_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_kind;
  logic [ROW_W-1:0]        out_row;
  logic [ROW_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [SIZE_W-1:0]       cfg_data = '0;
  int                      fail_count;
  int                      pending;

  int                      send_gap_pct = 0;
  int                      stall_pct = 0;
  bit                      hold_req = 1'b0;
  int                      hold_left = 0;
  bit                      loaded_a [DEPTH];
  bit                      loaded_b [DEPTH];
  int                      random_items = 0;
  logic [SIZE_W-1:0]       size_now = SIZE_W'(DIM);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_multiply_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  matrix_multiply_engine_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input cmd_t cmd, input int r, input int c,
                           input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_row <= ROW_W'(r);
    in_col <= ROW_W'(c);
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_LOAD_A) loaded_a[r * DIM + c] = 1'b1;
    if (cmd == CMD_LOAD_B) loaded_b[r * DIM + c] = 1'b1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_now = v;
  endtask

  task automatic send_read(input int n);
    if ($urandom_range(4) != 0)
      send_item(CMD_READ_C, $urandom_range(n - 1), $urandom_range(n - 1), pick_value());
    else
      send_item(CMD_READ_C, $urandom_range(15), $urandom_range(15), pick_value());
    random_items++;
  endtask

  // fill the active corner, multiply, read back with some noise mixed in
  task automatic fill_and_multiply(input int n, input int reload_pct);
    int i;
    int j;
    int reads;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        if (!loaded_a[i * DIM + j] || $urandom_range(99) < reload_pct) begin
          send_item(CMD_LOAD_A, i, j, pick_value());
          random_items++;
        end
        if (!loaded_b[i * DIM + j] || $urandom_range(99) < reload_pct) begin
          send_item(CMD_LOAD_B, i, j, pick_value());
          random_items++;
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: send_item(CMD_LOAD_A, $urandom_range(15), $urandom_range(15), pick_value());
            1: send_item(CMD_LOAD_B, $urandom_range(15), $urandom_range(15), pick_value());
            default: send_item(CMD_READ_C, $urandom_range(15), $urandom_range(15), pick_value());
          endcase
          random_items++;
        end
      end
    end
    send_item(CMD_COMPUTE, $urandom_range(15), $urandom_range(15), pick_value());
    random_items++;
    reads = n * n / 2 + 3;
    if (reads > 40) reads = 40;
    repeat (reads) send_read(n);
    if ($urandom_range(5) == 0) begin
      send_item(CMD_COMPUTE, $urandom_range(15), $urandom_range(15), pick_value());
      random_items++;
      repeat (3) send_read(n);
    end
  endtask

  initial begin
    int ph;
    int n;
    logic [SIZE_W-1:0] v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(CMD_READ_C, 0, 0, 16'h0000);
    send_item(CMD_READ_C, 15, 15, 16'hffff);
    set_size(5'd1);
    send_item(CMD_LOAD_A, 0, 0, 16'h8000);
    send_item(CMD_LOAD_B, 0, 0, 16'h8000);
    send_item(CMD_COMPUTE, 0, 0, 16'h0000);
    send_item(CMD_READ_C, 0, 0, 16'h0000);
    send_item(CMD_LOAD_A, 0, 0, 16'h7fff);
    send_item(CMD_COMPUTE, 15, 15, 16'hffff);
    send_item(CMD_READ_C, 0, 0, 16'h0000);
    send_item(CMD_LOAD_B, 0, 0, 16'h7fff);
    send_item(CMD_COMPUTE, 0, 0, 16'h0000);
    send_item(CMD_READ_C, 0, 0, 16'h0000);
    // entries beyond the active size still load; reads there return zero
    send_item(CMD_LOAD_A, 15, 15, 16'h5555);
    send_item(CMD_LOAD_B, 15, 0, 16'haaaa);
    send_item(CMD_READ_C, 15, 15, 16'h0000);
    send_item(CMD_READ_C, 15, 0, 16'h0000);
    send_item(CMD_READ_C, 0, 15, 16'h0000);
    // zero size acts as one
    set_size(5'd0);
    send_item(CMD_COMPUTE, 0, 0, 16'h0000);
    send_item(CMD_READ_C, 0, 0, 16'h0000);

    // random phases
    ph = 0;
    while (random_items < 1700) begin
      case (ph % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_gap_pct = 15;
          stall_pct = 15;
        end
      endcase
      if (ph == 1) v = 5'd16;
      else if (ph == 2) v = 5'd31;
      else if (ph == 4) v = 5'd0;
      else if (ph == 6) v = SIZE_W'($urandom_range(17, 30));
      else if (ph > 2 && $urandom_range(7) == 0) v = SIZE_W'($urandom_range(7, 15));
      else v = SIZE_W'($urandom_range(1, 6));
      set_size(v);
      n = int'(size_now);
      if (n < 1) n = 1;
      if (n > DIM) n = DIM;
      fill_and_multiply(n, (n > 6) ? 10 : 90);
      if (ph == 3) begin
        // long receiver hold-off with reads offered back to back
        send_gap_pct = 0;
        hold_req = 1'b1;
        repeat (40) send_read(n);
      end
      ph++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
